// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker module of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/pngr_pkg.sv
// Shared types and constants of the peak normalizing gain ramp.
package pngr_pkg;

  localparam int unsigned SMP_W     = 24;
  localparam int unsigned GAIN_W    = 32;
  localparam int unsigned CNT_W     = 18;
  localparam int unsigned POS_W     = 16;
  localparam int unsigned PEAK_W    = 23;
  localparam int unsigned MG_W      = 17;
  localparam int unsigned MM_W      = 24;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned LEN_W     = 7;
  localparam int unsigned DIVN_W    = 52;
  localparam int unsigned DIVD_W    = 23;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 24;

  localparam int unsigned BLOCK_SAMPLES_DEF = 64;
  localparam int unsigned POSITION_WRAP_DEF = 64000;

  localparam logic [GAIN_W-1:0] GAIN_ONE      = 32'h1000_0000;
  localparam logic [PEAK_W-1:0] SILENCE_FLOOR = 23'd666;
  localparam logic [MG_W-1:0]   NO_FADE_GAIN  = 17'd64225;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_MULT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEREO_MODE = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_SCAN_END,
    ST_DIVT_GO,
    ST_DIVT_WAIT,
    ST_TGT_LD,
    ST_STEP_GO,
    ST_STEP_WAIT,
    ST_STEP_LD,
    ST_EM_RD,
    ST_EM_GAIN,
    ST_EM_MUL,
    ST_EM_OUT,
    ST_FINISH
  } ctrl_state_e;

  typedef struct packed {
    logic             store_wr;
    logic             rd_en;
    logic [IDX_W-1:0] idx;
    logic             scan_clr;
    logic             scan_ev;
    logic             divt_start;
    logic             tgt_ld;
    logic             step_start;
    logic             step_ld;
    logic             em_gain;
    logic             em_mul;
    logic             em_load;
    logic             em_last;
    logic             blk_done;
  } dp_cmd_t;

  typedef struct packed {
    logic             blk_end;
    logic [LEN_W-1:0] blk_len;
    logic             peak_seen;
    logic             div_done;
    logic             out_free;
  } dp_sts_t;

endpackage

// File: hw/rtl/pngr_div.sv
// Restoring divider that retires one quotient bit per cycle.
module pngr_div
  import pngr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIVN_W-1:0] dividend_i,
  input  logic [DIVD_W-1:0] divisor_i,
  output logic [DIVN_W-1:0] quotient_o,
  output logic              done_o
);

  localparam int unsigned CW = $clog2(DIVN_W);

  logic [DIVD_W-1:0] rem_q, rem_d;
  logic [DIVN_W-1:0] quo_q, quo_d;
  logic [DIVD_W-1:0] dvs_q;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DIVD_W:0]   trial;
  logic [DIVD_W:0]   diff;
  logic              take;

  assign trial = {rem_q, quo_q[DIVN_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign take  = trial >= {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      cnt_d  = CW'(DIVN_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = take ? diff[DIVD_W-1:0] : trial[DIVD_W-1:0];
      quo_d = {quo_q[DIVN_W-2:0], take};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

// File: hw/rtl/pngr_dp.sv
// Datapath: configuration, sample store, peak scan, gain ramp and output register.
module pngr_dp
  import pngr_pkg::*;
#(
  parameter int unsigned BLOCK_SAMPLES = BLOCK_SAMPLES_DEF,
  parameter int unsigned POSITION_WRAP = POSITION_WRAP_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic signed [SMP_W-1:0] left_sample_i,
  input  logic signed [SMP_W-1:0] right_sample_i,
  input  logic                 last_of_block_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic signed [SMP_W-1:0] left_out_o,
  output logic signed [SMP_W-1:0] right_out_o,
  output logic                 last_out_o,
  input  dp_cmd_t              cmd_i,
  output dp_sts_t              sts_o
);

  localparam logic [LEN_W-1:0] BLK  = LEN_W'(BLOCK_SAMPLES);
  localparam logic [POS_W:0]   WRAP = (POS_W + 1)'(POSITION_WRAP);
  localparam int unsigned      PW   = SMP_W + GAIN_W + 1;

  function automatic logic [PEAK_W-1:0] abs_sat(input logic signed [SMP_W-1:0] s);
    logic [SMP_W-1:0] m;
    m = s[SMP_W-1] ? SMP_W'(-s) : s;
    if (m[SMP_W-1]) begin
      return '1;
    end
    return m[PEAK_W-1:0];
  endfunction

  function automatic logic [SMP_W-1:0] rnd_sat(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] s;
    logic signed [PW-29:0] q;
    s = p + PW'(64'sd134217728);
    q = (PW - 28)'(s >>> 28);
    if (q > (PW - 28)'(64'sd8388607)) begin
      return 24'h7FFFFF;
    end
    if (q < -(PW - 28)'(64'sd8388608)) begin
      return 24'h800000;
    end
    return q[SMP_W-1:0];
  endfunction

  logic [MG_W-1:0]   max_gain_q;
  logic [MM_W-1:0]   max_mult_q;
  logic [CNT_W-1:0]  attack_q, release_q;
  logic              stereo_q;

  logic [2*SMP_W-1:0] mem [1 << IDX_W];
  logic [2*SMP_W-1:0] rdata_q;
  logic [LEN_W-1:0]   fill_q, len_q, fill_inc;

  logic [PEAK_W-1:0] peak_q, peak_d;
  logic              seen_q, seen_d;
  logic [POS_W-1:0]  ppos_q, ppos_d, prev_q, offs_q;
  logic [GAIN_W-1:0] gain_q, gain_d, tgt_q, step_q;
  logic [CNT_W-1:0]  ae_q, ae_d, re_q, re_d;
  logic              fast_q;

  logic signed [PW-1:0] prod_l_q, prod_r_q;
  logic              out_valid_q;
  logic [SMP_W-1:0]  left_q, right_q;
  logic              last_q;

  logic signed [SMP_W-1:0] sl, sr;
  logic [PEAK_W-1:0] al, ar;
  logic [POS_W:0]    pos_sum, pos_w;
  logic              rising;
  logic [GAIN_W-1:0] diff;
  logic [CNT_W-1:0]  rem;
  logic [POS_W-1:0]  pos_gap;
  logic [DIVN_W-1:0] div_n, quo;
  logic [DIVD_W-1:0] div_d;
  logic              div_done;
  logic [GAIN_W-1:0] cap;
  logic [GAIN_W:0]   g_up;
  logic [CNT_W-1:0]  ae_inc, re_inc;

  assign fill_inc = fill_q + LEN_W'(1);
  assign sl       = rdata_q[2*SMP_W-1:SMP_W];
  assign sr       = rdata_q[SMP_W-1:0];
  assign al       = abs_sat(sl);
  assign ar       = abs_sat(sr);
  assign pos_sum  = (POS_W + 1)'(cmd_i.idx) + {1'b0, offs_q};
  assign pos_w    = (pos_sum >= WRAP) ? pos_sum - WRAP : pos_sum;
  assign rising   = tgt_q > gain_q;
  assign diff     = rising ? tgt_q - gain_q : gain_q - tgt_q;
  assign pos_gap  = (ppos_q > prev_q) ? ppos_q - prev_q : prev_q - ppos_q;
  assign cap      = {max_mult_q, 8'd0};
  assign g_up     = {1'b0, gain_q} + {1'b0, step_q};
  assign ae_inc   = ae_q + CNT_W'(1);
  assign re_inc   = re_q + CNT_W'(1);

  always_comb begin
    if (rising) begin
      rem = (attack_q > ae_q) ? attack_q - ae_q : CNT_W'(1);
    end else begin
      rem = (release_q > re_q) ? release_q - re_q : CNT_W'(1);
    end
  end

  assign div_n = cmd_i.divt_start ? {max_gain_q, 35'd0} : DIVN_W'(diff);
  assign div_d = cmd_i.divt_start ? peak_q : DIVD_W'(rem);

  pngr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.divt_start | cmd_i.step_start),
    .dividend_i (div_n),
    .divisor_i  (div_d),
    .quotient_o (quo),
    .done_o     (div_done)
  );

  always_comb begin
    peak_d = peak_q;
    seen_d = seen_q;
    ppos_d = ppos_q;
    if (cmd_i.scan_clr) begin
      peak_d = '0;
      seen_d = 1'b0;
      ppos_d = '0;
    end else if (cmd_i.scan_ev) begin
      if (al > peak_d && al > SILENCE_FLOOR) begin
        peak_d = al;
        seen_d = 1'b1;
        ppos_d = pos_w[POS_W-1:0];
      end
      if (stereo_q && ar > peak_d && ar > SILENCE_FLOOR) begin
        peak_d = ar;
        seen_d = 1'b1;
        ppos_d = pos_w[POS_W-1:0];
      end
    end
  end

  always_comb begin
    gain_d = gain_q;
    ae_d   = ae_q;
    re_d   = re_q;
    if (cmd_i.step_start) begin
      if (rising) begin
        re_d = '0;
      end else begin
        ae_d = '0;
      end
    end else if (cmd_i.em_gain && seen_q) begin
      if (rising) begin
        gain_d = (g_up > {1'b0, tgt_q}) ? tgt_q : g_up[GAIN_W-1:0];
        ae_d   = ae_inc;
        if (ae_inc == attack_q) begin
          ae_d   = '0;
          gain_d = tgt_q;
        end
      end else if (fast_q) begin
        re_d   = '0;
        gain_d = tgt_q;
      end else begin
        gain_d = (diff < step_q) ? tgt_q : gain_q - step_q;
        re_d   = re_inc;
        if (re_inc == release_q) begin
          re_d   = '0;
          gain_d = tgt_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_gain_q  <= 17'd65536;
      max_mult_q  <= 24'd15728640;
      attack_q    <= 18'd176400;
      release_q   <= 18'd7056;
      stereo_q    <= 1'b1;
      fill_q      <= '0;
      len_q       <= '0;
      peak_q      <= '0;
      seen_q      <= 1'b0;
      ppos_q      <= '0;
      prev_q      <= '0;
      offs_q      <= '0;
      gain_q      <= GAIN_ONE;
      tgt_q       <= GAIN_ONE;
      ae_q        <= '0;
      re_q        <= '0;
      fast_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MAX_GAIN:    max_gain_q <= cfg_wdata_i[MG_W-1:0];
          CFG_MAX_MULT:    max_mult_q <= cfg_wdata_i[MM_W-1:0];
          CFG_ATTACK:      attack_q   <= cfg_wdata_i[CNT_W-1:0];
          CFG_RELEASE:     release_q  <= cfg_wdata_i[CNT_W-1:0];
          CFG_STEREO_MODE: stereo_q   <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (cmd_i.store_wr) begin
        if (sts_o.blk_end) begin
          fill_q <= '0;
          len_q  <= fill_inc;
        end else begin
          fill_q <= fill_inc;
        end
      end
      peak_q <= peak_d;
      seen_q <= seen_d;
      ppos_q <= ppos_d;
      gain_q <= gain_d;
      ae_q   <= ae_d;
      re_q   <= re_d;
      if (cmd_i.tgt_ld) begin
        tgt_q <= (quo > DIVN_W'(cap)) ? cap : quo[GAIN_W-1:0];
      end
      if (cmd_i.step_start) begin
        fast_q <= (CNT_W'(pos_gap) < release_q) && (max_gain_q > NO_FADE_GAIN);
      end
      if (cmd_i.blk_done && seen_q) begin
        offs_q <= ppos_q;
        prev_q <= ppos_q;
      end
      if (cmd_i.em_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_wr) begin
      mem[fill_q[IDX_W-1:0]] <= {left_sample_i, right_sample_i};
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[cmd_i.idx];
    end
    if (cmd_i.step_ld) begin
      step_q <= quo[GAIN_W-1:0];
    end
    if (cmd_i.em_mul) begin
      prod_l_q <= sl * $signed({1'b0, gain_q});
      prod_r_q <= sr * $signed({1'b0, gain_q});
    end
    if (cmd_i.em_load) begin
      left_q  <= seen_q ? rnd_sat(prod_l_q) : sl;
      right_q <= !stereo_q ? '0 : (seen_q ? rnd_sat(prod_r_q) : sr);
      last_q  <= cmd_i.em_last;
    end
  end

  assign sts_o.blk_end   = cmd_i.store_wr && (last_of_block_i || fill_inc == BLK);
  assign sts_o.blk_len   = len_q;
  assign sts_o.peak_seen = seen_q;
  assign sts_o.div_done  = div_done;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign left_out_o  = left_q;
  assign right_out_o = right_q;
  assign last_out_o  = last_q;

endmodule

// File: hw/rtl/pngr_ctrl.sv
// Controller state machine that sequences collection, scan, division and emission.
module pngr_ctrl
  import pngr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             last_idx;

  assign last_idx = (LEN_W'(idx_q) + LEN_W'(1)) == sts_i.blk_len;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    cmd_o      = '0;
    cmd_o.idx  = idx_q;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.store_wr = in_valid_i;
        if (sts_i.blk_end) begin
          cmd_o.scan_clr = 1'b1;
          idx_d          = '0;
          state_d        = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_SCAN_EV;
      end
      ST_SCAN_EV: begin
        cmd_o.scan_ev = 1'b1;
        if (last_idx) begin
          state_d = ST_SCAN_END;
        end else begin
          idx_d   = idx_q + IDX_W'(1);
          state_d = ST_SCAN_RD;
        end
      end
      ST_SCAN_END: begin
        idx_d   = '0;
        state_d = sts_i.peak_seen ? ST_DIVT_GO : ST_EM_RD;
      end
      ST_DIVT_GO: begin
        cmd_o.divt_start = 1'b1;
        state_d          = ST_DIVT_WAIT;
      end
      ST_DIVT_WAIT: begin
        if (sts_i.div_done) begin
          state_d = ST_TGT_LD;
        end
      end
      ST_TGT_LD: begin
        cmd_o.tgt_ld = 1'b1;
        state_d      = ST_STEP_GO;
      end
      ST_STEP_GO: begin
        cmd_o.step_start = 1'b1;
        state_d          = ST_STEP_WAIT;
      end
      ST_STEP_WAIT: begin
        if (sts_i.div_done) begin
          state_d = ST_STEP_LD;
        end
      end
      ST_STEP_LD: begin
        cmd_o.step_ld = 1'b1;
        idx_d         = '0;
        state_d       = ST_EM_RD;
      end
      ST_EM_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_EM_GAIN;
      end
      ST_EM_GAIN: begin
        cmd_o.em_gain = 1'b1;
        state_d       = ST_EM_MUL;
      end
      ST_EM_MUL: begin
        cmd_o.em_mul = 1'b1;
        state_d      = ST_EM_OUT;
      end
      ST_EM_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.em_load = 1'b1;
          cmd_o.em_last = last_idx;
          if (last_idx) begin
            state_d = ST_FINISH;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = ST_EM_RD;
          end
        end
      end
      ST_FINISH: begin
        cmd_o.blk_done = 1'b1;
        state_d        = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/peak_normalizing_gain_ramp.sv
// Top level of the peak normalizing gain ramp.
// Input channel: in_valid_i/in_ready_o carry one stereo or mono Q1.23 sample per
// transaction; last_of_block_i closes a block, which also closes at BLOCK_SAMPLES.
// Output channel: out_valid_o/out_ready_i carry one gained sample per transaction,
// last_out_o marking the final sample of the block.
// Samples that do not close a block are taken in one cycle each.
// After the closing sample each of the n samples of the block is read from the store
// and then checked for the peak, and a final scan step closes the scan. A block with a
// peak then runs two divisions on the shared serial divider, for the target and the step,
// each with its start and load steps; a silent block skips them. Each sample is emitted
// through a store read, a gain update, a multiply and a round; in_ready_o stays low
// until the last result of the block has been loaded into the output register.
// A stalled receiver holds the output register and the emission waits on it.
// Reset restores the register defaults, sets the gain to one and empties the
// sample store; stored samples need no clearing.
module peak_normalizing_gain_ramp
  import pngr_pkg::*;
#(
  parameter int unsigned BLOCK_SAMPLES = BLOCK_SAMPLES_DEF,
  parameter int unsigned POSITION_WRAP = POSITION_WRAP_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_W-1:0]        cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [SMP_W-1:0] left_sample_i,
  input  logic signed [SMP_W-1:0] right_sample_i,
  input  logic                    last_of_block_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [SMP_W-1:0] left_out_o,
  output logic signed [SMP_W-1:0] right_out_o,
  output logic                    last_out_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  pngr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pngr_dp #(
    .BLOCK_SAMPLES (BLOCK_SAMPLES),
    .POSITION_WRAP (POSITION_WRAP)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .left_sample_i   (left_sample_i),
    .right_sample_i  (right_sample_i),
    .last_of_block_i (last_of_block_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .left_out_o      (left_out_o),
    .right_out_o     (right_out_o),
    .last_out_o      (last_out_o),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule

// File: hw/rtl/pngr_checker.sv
// Port-level assertions for the peak normalizing gain ramp and their bind.
`include "assert_macros.svh"

module pngr_checker
  import pngr_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic             last_of_block_i,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [SMP_W-1:0] left_out_o,
  input logic [SMP_W-1:0] right_out_o,
  input logic             last_out_o
);

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(left_out_o) && $stable(right_out_o) && $stable(last_out_o))
  `ASSERT_NEXT(a_block_closes, clk_i, rst_ni, in_valid_i && in_ready_o && last_of_block_i, !in_ready_o)
  `ASSERT_SAME(a_emit_busy, clk_i, rst_ni, $rose(out_valid_o), !in_ready_o)

endmodule

bind peak_normalizing_gain_ramp pngr_checker u_pngr_checker (.*);

// File: test/peak_normalizing_gain_ramp_tb.sv
// Self-checking testbench of the peak normalizing gain ramp with its own block predictor.
`timescale 1ns / 1ps

module peak_normalizing_gain_ramp_tb;
  import pngr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned DRAIN_CYCLES = 40;

  typedef struct {
    logic signed [SMP_W-1:0] left;
    logic signed [SMP_W-1:0] right;
    logic                    last;
  } gained_sample_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CFG_IDX_W-1:0]    cfg_idx_i;
  logic [CFG_W-1:0]        cfg_wdata_i;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic signed [SMP_W-1:0] left_sample_i;
  logic signed [SMP_W-1:0] right_sample_i;
  logic                    last_of_block_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic signed [SMP_W-1:0] left_out_o;
  logic signed [SMP_W-1:0] right_out_o;
  logic                    last_out_o;

  peak_normalizing_gain_ramp i_dut (.*);

  always #5 clk_i = ~clk_i;

  // Predictor state and register copies.
  bit [MG_W-1:0]    max_gain_q;
  bit [MM_W-1:0]    max_mult_q;
  bit [CNT_W-1:0]   attack_len_q;
  bit [CNT_W-1:0]   release_len_q;
  bit               stereo_q;
  logic signed [SMP_W-1:0] held_left [64];
  logic signed [SMP_W-1:0] held_right [64];
  int unsigned      held_count;
  bit [PEAK_W-1:0]  peak_abs;
  bit [POS_W-1:0]   peak_pos;
  bit [POS_W-1:0]   prev_peak_pos;
  bit [POS_W-1:0]   pos_offset;
  bit               peak_found;
  bit [GAIN_W-1:0]  gain_now;
  bit [GAIN_W-1:0]  gain_goal;
  bit [CNT_W-1:0]   attack_count;
  bit [CNT_W-1:0]   release_count;

  gained_sample_t   gained_q[$];
  int unsigned      mismatches;
  int unsigned      results_checked;
  int unsigned      blocks_closed;
  int unsigned      cycle_count;
  int unsigned      hold_until;
  int unsigned      send_idle_pct;
  int unsigned      recv_stall_pct;

  function automatic bit [PEAK_W-1:0] magnitude(logic signed [SMP_W-1:0] s);
    longint a;
    a = (s < 0) ? -longint'(s) : longint'(s);
    return (a > 8388607) ? 23'h7FFFFF : a[PEAK_W-1:0];
  endfunction

  function automatic logic signed [SMP_W-1:0] scale_sample(logic signed [SMP_W-1:0] s,
                                                            bit [GAIN_W-1:0] g);
    longint p;
    longint q;
    p = longint'(s) * longint'({32'b0, g});
    q = (p + (64'sd1 <<< 27)) >>> 28;
    if (q > 8388607) q = 8388607;
    if (q < -8388608) q = -8388608;
    return q[SMP_W-1:0];
  endfunction

  task automatic track_peak(logic signed [SMP_W-1:0] s, int unsigned i);
    bit [PEAK_W-1:0] a;
    a = magnitude(s);
    if (a > peak_abs && a > SILENCE_FLOOR) begin
      peak_abs = a;
      peak_pos = POS_W'((i + pos_offset) % POSITION_WRAP_DEF);
      peak_found = 1'b1;
    end
  endtask

  task automatic normalize_block(int unsigned n);
    bit [63:0]       goal;
    bit [63:0]       cap;
    bit [63:0]       raised;
    bit [GAIN_W-1:0] step;
    bit [CNT_W-1:0]  remain;
    bit [POS_W-1:0]  peak_gap;
    bit              snap_release;
    gained_sample_t  r;
    peak_abs = '0;
    peak_pos = '0;
    peak_found = 1'b0;
    for (int unsigned i = 0; i < n; i++) begin
      track_peak(held_left[i], i);
      if (stereo_q) track_peak(held_right[i], i);
    end
    if (peak_found) begin
      goal = (64'(max_gain_q) << 35) / 64'(peak_abs);
      cap = 64'(max_mult_q) << 8;
      gain_goal = (goal > cap) ? cap[31:0] : goal[31:0];
      if (gain_goal > gain_now) begin
        remain = (attack_len_q > attack_count) ? attack_len_q - attack_count : CNT_W'(1);
        step = (gain_goal - gain_now) / remain;
        release_count = '0;
      end else begin
        remain = (release_len_q > release_count) ? release_len_q - release_count : CNT_W'(1);
        step = (gain_now - gain_goal) / remain;
        attack_count = '0;
      end
      peak_gap = (peak_pos > prev_peak_pos) ? peak_pos - prev_peak_pos
                                            : prev_peak_pos - peak_pos;
      snap_release = (CNT_W'(peak_gap) < release_len_q) && (max_gain_q > NO_FADE_GAIN);
      for (int unsigned i = 0; i < n; i++) begin
        if (gain_goal > gain_now) begin
          raised = 64'(gain_now) + 64'(step);
          gain_now = (raised > 64'(gain_goal)) ? gain_goal : raised[31:0];
          attack_count = attack_count + CNT_W'(1);
          if (attack_count == attack_len_q) begin
            attack_count = '0;
            gain_now = gain_goal;
          end
        end else if (snap_release) begin
          release_count = '0;
          gain_now = gain_goal;
        end else begin
          gain_now = (gain_now - gain_goal < step) ? gain_goal : gain_now - step;
          release_count = release_count + CNT_W'(1);
          if (release_count == release_len_q) begin
            release_count = '0;
            gain_now = gain_goal;
          end
        end
        r.left = scale_sample(held_left[i], gain_now);
        r.right = stereo_q ? scale_sample(held_right[i], gain_now) : '0;
        r.last = (i + 1 == n);
        gained_q.push_back(r);
      end
      pos_offset = POS_W'(peak_pos % POSITION_WRAP_DEF);
      prev_peak_pos = peak_pos;
    end else begin
      for (int unsigned i = 0; i < n; i++) begin
        r.left = held_left[i];
        r.right = stereo_q ? held_right[i] : '0;
        r.last = (i + 1 == n);
        gained_q.push_back(r);
      end
    end
    blocks_closed++;
  endtask

  task automatic take_sample(logic signed [SMP_W-1:0] l, logic signed [SMP_W-1:0] r,
                             logic last);
    held_left[held_count % 64] = l;
    held_right[held_count % 64] = r;
    held_count = (held_count + 1) & 7'h7F;
    if (last || held_count >= BLOCK_SAMPLES_DEF) begin
      normalize_block(held_count);
      held_count = 0;
    end
  endtask

  task automatic send_sample(logic signed [SMP_W-1:0] l, logic signed [SMP_W-1:0] r,
                             logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    left_sample_i <= l;
    right_sample_i <= r;
    last_of_block_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    take_sample(l, r, last);
  endtask

  function automatic logic signed [SMP_W-1:0] random_sample();
    case ($urandom_range(5))
      0: return SMP_W'(int'($urandom_range(1332)) - 666);
      1: return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
      2: return SMP_W'(int'($urandom_range(200000)) - 100000);
      default: return SMP_W'($urandom);
    endcase
  endfunction

  task automatic send_block(int unsigned len, bit close_with_last);
    for (int unsigned i = 0; i < len; i++)
      send_sample(random_sample(), random_sample(), close_with_last && (i + 1 == len));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (gained_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, bit [CFG_W-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    case (idx)
      CFG_MAX_GAIN:    max_gain_q = value[MG_W-1:0];
      CFG_MAX_MULT:    max_mult_q = value[MM_W-1:0];
      CFG_ATTACK:      attack_len_q = value[CNT_W-1:0];
      CFG_RELEASE:     release_len_q = value[CNT_W-1:0];
      CFG_STEREO_MODE: stereo_q = value[0];
      default: ;
    endcase
  endtask

  task automatic configure(bit [CFG_W-1:0] mg, bit [CFG_W-1:0] mm, bit [CFG_W-1:0] att,
                           bit [CFG_W-1:0] rel, bit [CFG_W-1:0] stereo);
    write_reg(CFG_MAX_GAIN, mg);
    write_reg(CFG_MAX_MULT, mm);
    write_reg(CFG_ATTACK, att);
    write_reg(CFG_RELEASE, rel);
    write_reg(CFG_STEREO_MODE, stereo);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_directed_defaults();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_sample(24'sh7FFFFF, 24'sh000000, 1'b0);
    send_sample(24'sh800000, 24'sh7FFFFF, 1'b0);
    send_sample(24'sh000000, 24'sh800000, 1'b1);
    send_sample(24'sd666, -24'sd666, 1'b0);
    send_sample(-24'sd12, 24'sd300, 1'b1);
    send_sample(24'sd667, -24'sd500, 1'b1);
    send_sample(-24'sd667, 24'sd700, 1'b0);
    send_sample(24'sd100000, 24'sh555555, 1'b0);
    send_sample(24'shAAAAAA, -24'sd1, 1'b1);
    send_sample(24'sd4000000, 24'sd20, 1'b1);
    drain();
  endtask

  task automatic test_extreme_settings();
    configure(24'd0, 24'd0, 24'd1, 24'd1, 24'd0);
    send_sample(24'sd8000, 24'sh7FFFFF, 1'b0);
    send_sample(24'sh800000, 24'sd5, 1'b1);
    send_sample(24'sd100, 24'sh7FFFFF, 1'b1);
    drain();
    configure(24'd65536, 24'hFFFFFF, 24'd262143, 24'd262143, 24'd1);
    send_sample(24'sd1000, 24'sd900, 1'b0);
    send_sample(-24'sd800, 24'sd700, 1'b1);
    send_sample(24'sh7FFFFF, 24'sd1, 1'b1);
    send_sample(24'sd2000, -24'sd3000, 1'b1);
    drain();
    configure(24'd60000, 24'd3000000, 24'd3, 24'd2, 24'd1);
    send_sample(24'sd900, 24'sd100, 1'b1);
    send_sample(24'sh7FFFFF, 24'sd100, 1'b0);
    send_sample(24'sd20000, 24'sd100, 1'b1);
    send_sample(24'sd20000, 24'sd100, 1'b1);
    drain();
  endtask

  task automatic test_random_phase(int unsigned idle, int unsigned stall, int unsigned blocks);
    configure(CFG_W'($urandom_range(65536)),
              CFG_W'($urandom_range(24'hFFFFFF) >> $urandom_range(8)),
              CFG_W'($urandom_range(1, 40)), CFG_W'($urandom_range(1, 40)),
              CFG_W'($urandom_range(1)));
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int unsigned b = 0; b < blocks; b++) begin
      send_block($urandom_range(1, 4), 1'b1);
    end
    drain();
  endtask

  task automatic test_backpressure();
    configure(24'd65536, 24'd15728640, 24'd176400, 24'd7056, 24'd1);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_until = cycle_count + 3000;
    send_block(BLOCK_SAMPLES_DEF, 1'b0);
    send_block(6, 1'b1);
    drain();
  endtask

  always @(posedge clk_i) begin
    gained_sample_t want;
    if (out_valid_o && out_ready_i) begin
      if (gained_q.size() == 0) begin
        $error("unexpected result transaction: left %0d right %0d last %0b",
               left_out_o, right_out_o, last_out_o);
        mismatches++;
      end else begin
        want = gained_q.pop_front();
        results_checked++;
        if (left_out_o !== want.left) begin
          $error("left_out expected %0d actual %0d", want.left, left_out_o);
          mismatches++;
        end
        if (right_out_o !== want.right) begin
          $error("right_out expected %0d actual %0d", want.right, right_out_o);
          mismatches++;
        end
        if (last_out_o !== want.last) begin
          $error("last_out expected %0b actual %0b", want.last, last_out_o);
          mismatches++;
        end
      end
    end
    out_ready_i <= (cycle_count >= hold_until) && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("peak_normalizing_gain_ramp_tb failed");
      $finish;
    end
  end

  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CFG_MAX_GAIN;
    cfg_wdata_i <= '0;
    in_valid_i <= 1'b0;
    left_sample_i <= '0;
    right_sample_i <= '0;
    last_of_block_i <= 1'b0;
    out_ready_i <= 1'b0;
    cycle_count = 0;
    hold_until = 0;
    mismatches = 0;
    results_checked = 0;
    blocks_closed = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    max_gain_q = 17'd65536;
    max_mult_q = 24'd15728640;
    attack_len_q = 18'd176400;
    release_len_q = 18'd7056;
    stereo_q = 1'b1;
    held_count = 0;
    peak_abs = '0;
    peak_pos = '0;
    prev_peak_pos = '0;
    pos_offset = '0;
    peak_found = 1'b0;
    gain_now = GAIN_ONE;
    gain_goal = GAIN_ONE;
    attack_count = '0;
    release_count = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_defaults();
    test_extreme_settings();
    test_random_phase(0, 0, 3);
    test_random_phase(86, 0, 3);
    test_random_phase(0, 86, 3);
    test_random_phase(24, 24, 3);
    test_random_phase(0, 0, 3);
    test_backpressure();

    $display("Covered %0d blocks and %0d checked samples over extreme and random settings,",
             blocks_closed, results_checked);
    $display("with idle and stall phases and a long receiver hold-off.");
    if (mismatches == 0) begin
      $display("peak_normalizing_gain_ramp_tb passed");
    end else begin
      $display("peak_normalizing_gain_ramp_tb failed");
    end
    $finish;
  end

endmodule

// File: peak_normalizing_gain_ramp.f
+incdir+hw/rtl
hw/rtl/pngr_pkg.sv
hw/rtl/pngr_div.sv
hw/rtl/pngr_dp.sv
hw/rtl/pngr_ctrl.sv
hw/rtl/peak_normalizing_gain_ramp.sv
hw/rtl/pngr_checker.sv
test/peak_normalizing_gain_ramp_tb.sv
